// ----- src/dfir_pkg.sv -----
// Shared types and constants of the decimating FIR filter.
`default_nettype none

package dfir_pkg;

   // Field widths of the transactions.
   localparam int TAP_W   = 7;
   localparam int VALUE_W = 16;
   localparam int RES_W   = 17;
   localparam int DEC_W   = 8;
   localparam int GAIN_W  = 17;
   localparam int CSR_A_W = 2;
   localparam int CSR_D_W = 17;
   localparam int PROD_W  = 32;

   // Operation carried in the request tuser bit.
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_PUSH = 1'b1;

   // Register indexes of the configuration port.
   localparam logic [CSR_A_W-1:0] CSR_DECIMATION = 2'd0;
   localparam logic [CSR_A_W-1:0] CSR_GAIN       = 2'd1;

   // Reset values of the configuration registers.
   localparam logic [DEC_W-1:0]  DEC_RESET  = 8'd10;
   localparam logic [GAIN_W-1:0] GAIN_RESET = 17'd1638;

   // Saturation limits of the result.
   localparam logic [RES_W-1:0] RES_MAX = 17'h0FFFF;
   localparam logic [RES_W-1:0] RES_MIN = 17'h10000;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_WAIT,
      ST_DELIVER
   } dfir_state_type;

   // Control that travels with each tap read into the MAC pipeline.
   typedef struct packed {
      logic issue;
      logic first;
      logic last;
   } dfir_mac_ctl_type;

endpackage

`default_nettype wire

// ----- src/dfir_mem.sv -----
// Coefficient store and circular sample window, both synchronous RAMs.
`default_nettype none

module dfir_mem
   import dfir_pkg::*;
#(
   parameter int TAPS = 80
) (
   input  wire logic                              clock,
   input  wire logic                              coef_we,
   input  wire logic [(TAPS > 1 ? $clog2(TAPS) : 1)-1:0] coef_waddr,
   input  wire logic signed [VALUE_W-1:0]         coef_wdata,
   input  wire logic [(TAPS > 1 ? $clog2(TAPS) : 1)-1:0] coef_raddr,
   output logic signed [VALUE_W-1:0]              coef_rdata,
   input  wire logic                              samp_we,
   input  wire logic [(TAPS > 1 ? $clog2(TAPS) : 1)-1:0] samp_waddr,
   input  wire logic signed [VALUE_W-1:0]         samp_wdata,
   input  wire logic [(TAPS > 1 ? $clog2(TAPS) : 1)-1:0] samp_raddr,
   output logic signed [VALUE_W-1:0]              samp_rdata
);

   logic signed [VALUE_W-1:0] coef_mem [TAPS];
   logic signed [VALUE_W-1:0] samp_mem [TAPS];

   // Coefficient RAM: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (coef_we) begin
         coef_mem[coef_waddr] <= coef_wdata;
      end
      coef_rdata <= coef_mem[coef_raddr];
   end

   // Sample RAM: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (samp_we) begin
         samp_mem[samp_waddr] <= samp_wdata;
      end
      samp_rdata <= samp_mem[samp_raddr];
   end

endmodule

`default_nettype wire

// ----- src/dfir_mac.sv -----
// Multiply-accumulate pipeline with the output shift, gain and saturation.
`default_nettype none

module dfir_mac
   import dfir_pkg::*;
#(
   parameter int TAPS = 80
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire dfir_mac_ctl_type          ctl,
   input  wire logic signed [VALUE_W-1:0] coef_rd,
   input  wire logic signed [VALUE_W-1:0] samp_rd,
   input  wire logic [GAIN_W-1:0]         gain,
   output logic                           done,
   output logic signed [RES_W-1:0]        result
);

   localparam int ACC_W = PROD_W + $clog2(TAPS);
   localparam int SH_W  = ACC_W - 15;
   localparam int GP_W  = SH_W + GAIN_W + 1;
   localparam int GS_W  = GP_W - 16;

   dfir_mac_ctl_type         ctl1_ff;
   dfir_mac_ctl_type         ctl2_ff;
   logic                     scale_go_ff;
   logic                     sat_go_ff;
   logic                     done_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [GP_W-1:0]   gprod_ff;
   logic signed [RES_W-1:0]  result_ff;

   logic signed [SH_W-1:0]   acc_sh;
   logic signed [GAIN_W:0]   gain_s;
   logic signed [GS_W-1:0]   gprod_sh;
   logic [GS_W-RES_W:0]      upper;
   logic signed [RES_W-1:0]  result_in;

   // Control follows the data through the read, multiply and add stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff     <= '0;
         ctl2_ff     <= '0;
         scale_go_ff <= 1'b0;
         sat_go_ff   <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         ctl1_ff     <= ctl;
         ctl2_ff     <= ctl1_ff;
         scale_go_ff <= ctl2_ff.issue & ctl2_ff.last;
         sat_go_ff   <= scale_go_ff;
         done_ff     <= sat_go_ff;
      end
   end

   // One product per cycle from the registered RAM outputs.
   always_ff @(posedge clock) begin
      if (ctl1_ff.issue) begin
         prod_ff <= coef_rd * samp_rd;
      end
   end

   // Accumulator restarts on the first tap of a window.
   always_ff @(posedge clock) begin
      if (ctl2_ff.issue) begin
         if (ctl2_ff.first) begin
            acc_ff <= ACC_W'(prod_ff);
         end else begin
            acc_ff <= acc_ff + ACC_W'(prod_ff);
         end
      end
   end

   // Drop the Q15 fraction and apply the gain.
   assign acc_sh = acc_ff[ACC_W-1:15];
   assign gain_s = {1'b0, gain};

   always_ff @(posedge clock) begin
      if (scale_go_ff) begin
         gprod_ff <= acc_sh * gain_s;
      end
   end

   // Second shift, then saturate when the upper bits disagree with the sign.
   assign gprod_sh = gprod_ff[GP_W-1:16];
   assign upper    = gprod_sh[GS_W-1:RES_W-1];

   always_comb begin
      if ((&upper) || !(|upper)) begin
         result_in = gprod_sh[RES_W-1:0];
      end else if (gprod_sh[GS_W-1]) begin
         result_in = RES_MIN;
      end else begin
         result_in = RES_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (sat_go_ff) begin
         result_ff <= result_in;
      end
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

`default_nettype wire

// ----- src/decimating_fir_filter.sv -----
// Top level of the decimating FIR filter: sequencer, counters and channels.
//
// Usage:
//   The req channel carries one transaction per item. req_tuser selects the
//   operation: a coefficient load writes tap req_tdata[6:0] with the value in
//   req_tdata[22:7]; a sample push shifts that value into the sample window.
//   Loads and pushes that give no output leave the block idle, ready for the next item.
//   When a push fills the window, and every decimation-th push after that,
//   the block runs one multiply-accumulate over all TAPS taps, reading the
//   coefficient and sample RAMs at one address each per cycle. Such a push
//   passes the issue, wait and deliver states before its rsp transaction; req_tready
//   is low while the taps are processed.
//   The result sits in an output register, so further items are accepted
//   while rsp waits; a stalled receiver holds only the next output pass.
//   Reset clears the window fill count, the phase count and the output valid, and
//   sets decimation to 10 and output gain to 1638. Coefficients must be
//   loaded before the first output. The csr port is always ready and must be
//   written only while the block is idle; the block itself does not enforce this.
`default_nettype none

module decimating_fir_filter
   import dfir_pkg::*;
#(
   parameter int TAPS = 80
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [23:0]          req_tdata,  // tap_index[6:0], value[22:7], zero pad
   input  wire logic                 req_tuser,  // opcode
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [23:0]               rsp_tdata,  // filtered[16:0], zero pad
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_A_W-1:0]   csr_index,
   input  wire logic [CSR_D_W-1:0]   csr_data
);

   localparam int ADDR_W = (TAPS > 1) ? $clog2(TAPS) : 1;
   localparam int FILL_W = $clog2(TAPS + 1);

   dfir_state_type            state_ff, state_in;
   logic [ADDR_W-1:0]         wp_ff, wp_in;
   logic [ADDR_W-1:0]         rp_ff, rp_in;
   logic [ADDR_W-1:0]         k_ff, k_in;
   logic [FILL_W-1:0]         fill_ff, fill_in;
   logic [DEC_W-1:0]          phase_ff, phase_in;
   logic [DEC_W-1:0]          dec_ff;
   logic [GAIN_W-1:0]         gain_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [RES_W-1:0]   rsp_data_ff, rsp_data_in;

   logic                      req_fire;
   logic [TAP_W-1:0]          tap_index;
   logic signed [VALUE_W-1:0] value;
   logic [8:0]                tap_wide;
   logic                      tap_in_range;
   logic [ADDR_W-1:0]         wp_next;
   logic [ADDR_W-1:0]         rp_next;
   logic [DEC_W-1:0]          dec_eff;
   logic [DEC_W-1:0]          phase_next;
   logic                      coef_we;
   logic                      samp_we;
   logic                      out_free;
   dfir_mac_ctl_type          mac_ctl;
   logic signed [VALUE_W-1:0] coef_rd;
   logic signed [VALUE_W-1:0] samp_rd;
   logic                      mac_done;
   logic signed [RES_W-1:0]   mac_result;

   // Request decode.
   assign req_tready   = (state_ff == ST_IDLE);
   assign req_fire     = req_tvalid & req_tready;
   assign tap_index    = req_tdata[TAP_W-1:0];
   assign value        = req_tdata[TAP_W+VALUE_W-1:TAP_W];
   assign tap_wide     = {2'b00, tap_index};
   assign tap_in_range = (tap_wide < 9'(TAPS));
   assign coef_we      = req_fire && (req_tuser == OP_LOAD) && tap_in_range;
   assign samp_we      = req_fire && (req_tuser == OP_PUSH);

   // Circular pointers and the decimation phase.
   assign wp_next    = (wp_ff == ADDR_W'(TAPS - 1)) ? '0 : wp_ff + 1'b1;
   assign rp_next    = (rp_ff == ADDR_W'(TAPS - 1)) ? '0 : rp_ff + 1'b1;
   assign dec_eff    = (dec_ff == '0) ? 8'd1 : dec_ff;
   assign phase_next = phase_ff + 8'd1;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dec_ff  <= DEC_RESET;
         gain_ff <= GAIN_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_DECIMATION: dec_ff  <= csr_data[DEC_W-1:0];
            CSR_GAIN:       gain_ff <= csr_data[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   // Sequencer: next state, counters and MAC control.
   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      rp_in        = rp_ff;
      k_in         = k_ff;
      fill_in      = fill_ff;
      phase_in     = phase_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      mac_ctl      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (samp_we) begin
               wp_in = wp_next;
               rp_in = wp_next;
               k_in  = '0;
               if (fill_ff < FILL_W'(TAPS)) begin
                  fill_in = fill_ff + 1'b1;
                  if (fill_ff == FILL_W'(TAPS - 1)) begin
                     phase_in = '0;
                     state_in = ST_ISSUE;
                  end
               end else if (phase_next >= dec_eff) begin
                  phase_in = '0;
                  state_in = ST_ISSUE;
               end else begin
                  phase_in = phase_next;
               end
            end
         end
         ST_ISSUE: begin
            mac_ctl.issue = 1'b1;
            mac_ctl.first = (k_ff == '0);
            mac_ctl.last  = (k_ff == ADDR_W'(TAPS - 1));
            k_in          = k_ff + 1'b1;
            rp_in         = rp_next;
            if (mac_ctl.last) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (mac_done) begin
               state_in = ST_DELIVER;
            end
         end
         ST_DELIVER: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = mac_result;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         rp_ff        <= '0;
         k_ff         <= '0;
         fill_ff      <= '0;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         k_ff         <= k_in;
         fill_ff      <= fill_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output payload register.
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_data_ff};

   dfir_mem #(
      .TAPS (TAPS)
   ) u_mem (
      .clock      (clock),
      .coef_we    (coef_we),
      .coef_waddr (tap_wide[ADDR_W-1:0]),
      .coef_wdata (value),
      .coef_raddr (k_ff),
      .coef_rdata (coef_rd),
      .samp_we    (samp_we),
      .samp_waddr (wp_ff),
      .samp_wdata (value),
      .samp_raddr (rp_ff),
      .samp_rdata (samp_rd)
   );

   dfir_mac #(
      .TAPS (TAPS)
   ) u_mac (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mac_ctl),
      .coef_rd (coef_rd),
      .samp_rd (samp_rd),
      .gain    (gain_ff),
      .done    (mac_done),
      .result  (mac_result)
   );

endmodule

`default_nettype wire

// ----- tb/tb_decimating_fir_filter.sv -----
// Self-checking testbench of the decimating FIR filter with a built-in output predictor.
`timescale 1ns / 100ps

module tb;
   import dfir_pkg::*;

   localparam int TAPS        = 80;
   localparam int SETTLE      = TAPS + 16;
   localparam int LONG_HOLD   = 1500;
   localparam int RAND_PHASES = 12;

   // Receiver behavior while taking outputs.
   typedef enum logic [1:0] {
      RX_ALWAYS,
      RX_RANDOM,
      RX_SPARSE,
      RX_PATTERN
   } rx_mode_type;

   // Tracks the filter state, predicts each output and compares the outputs in order.
   class filter_scoreboard;
      logic signed [VALUE_W-1:0] window [TAPS];
      logic signed [VALUE_W-1:0] coef [TAPS];
      int unsigned               fill_count;
      int unsigned               phase_count;
      logic [DEC_W-1:0]          decimation;
      logic [GAIN_W-1:0]         gain;
      logic [RES_W-1:0]          expected_outputs [$];
      int                        mismatches;
      int                        outputs_seen;

      function new();
         foreach (window[k]) begin
            window[k] = '0;
            coef[k]   = '0;
         end
         fill_count   = 0;
         phase_count  = 0;
         decimation   = DEC_RESET;
         gain         = GAIN_RESET;
         mismatches   = 0;
         outputs_seen = 0;
      endfunction

      function void flag(string msg);
         mismatches++;
         if (mismatches <= 10) begin
            $display("%t: %s", $realtime, msg);
         end
      endfunction

      function void write_reg(logic [CSR_A_W-1:0] index, logic [CSR_D_W-1:0] data);
         if (index == CSR_DECIMATION) begin
            decimation = data[DEC_W-1:0];
         end else if (index == CSR_GAIN) begin
            gain = data[GAIN_W-1:0];
         end
      endfunction

      // Sum of products, shifted, scaled by the gain, shifted again and saturated.
      function logic [RES_W-1:0] filter_output();
         longint acc;
         longint r;
         acc = 0;
         for (int k = 0; k < TAPS; k++) begin
            acc += longint'(coef[k]) * longint'(window[k]);
         end
         r = acc >>> 15;
         r = r * longint'(gain);
         r = r >>> 16;
         if (r > 65535) begin
            r = 65535;
         end
         if (r < -65536) begin
            r = -65536;
         end
         return r[RES_W-1:0];
      endfunction

      function void note_input(logic op, logic [TAP_W-1:0] tap, logic [VALUE_W-1:0] value);
         bit          emit;
         int unsigned dec;
         emit = 1'b0;
         // A load outside the tap range is dropped.
         if (op == OP_LOAD) begin
            if (tap < TAPS) begin
               coef[tap] = value;
            end
            return;
         end
         for (int k = 0; k < TAPS - 1; k++) begin
            window[k] = window[k + 1];
         end
         window[TAPS - 1] = value;
         // The first output comes when the window fills, then one every decimation pushes.
         if (fill_count < TAPS) begin
            fill_count++;
            if (fill_count == TAPS) begin
               emit        = 1'b1;
               phase_count = 0;
            end
         end else begin
            dec         = (decimation == 0) ? 1 : decimation;
            phase_count = (phase_count + 1) & 8'hFF;
            if (phase_count >= dec) begin
               emit        = 1'b1;
               phase_count = 0;
            end
         end
         if (emit) begin
            expected_outputs.push_back(filter_output());
         end
      endfunction

      function void check_output(logic [RES_W-1:0] actual);
         logic [RES_W-1:0] want;
         outputs_seen++;
         if (expected_outputs.size() == 0) begin
            flag($sformatf("output %0d arrived with none expected: got %h", outputs_seen, actual));
            return;
         end
         want = expected_outputs.pop_front();
         if (actual !== want) begin
            flag($sformatf("output %0d mismatch: expected %h, got %h", outputs_seen, want, actual));
         end
      endfunction

      function int pending();
         return expected_outputs.size();
      endfunction

      function void close_out();
         if (expected_outputs.size() != 0) begin
            mismatches += expected_outputs.size();
            $display("%0d expected outputs never arrived", expected_outputs.size());
         end
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [23:0]          req_tdata;   // tap_index[6:0], value[22:7], zero pad
   logic                 req_tuser;   // opcode
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [23:0]          rsp_tdata;   // filtered[16:0], zero pad
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_A_W-1:0]   csr_index;
   logic [CSR_D_W-1:0]   csr_data;

   filter_scoreboard sb = new();
   int               burst_left = 8;
   logic             hold_rsp = 1'b0;
   logic             long_hold_go = 1'b0;

   decimating_fir_filter #(
      .TAPS (TAPS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Every completed transaction is sampled at the clock edge that completes it.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            sb.write_reg(csr_index, csr_data);
         end
         if (rsp_tvalid && rsp_tready) begin
            sb.check_output(rsp_tdata[RES_W-1:0]);
         end
         if (req_tvalid && req_tready) begin
            sb.note_input(req_tuser, req_tdata[TAP_W-1:0], req_tdata[TAP_W +: VALUE_W]);
         end
      end
   end

   // The receiver picks a new stall mode at random whenever its run in the current mode ends.
   initial begin
      rx_mode_type mode;
      int          mode_left;
      logic [15:0] pattern;
      logic        ready;
      mode       = RX_ALWAYS;
      mode_left  = 0;
      pattern    = '1;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (mode_left == 0) begin
            mode      = rx_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 300);
            pattern   = 16'($urandom);
         end
         mode_left--;
         case (mode)
            RX_ALWAYS: ready = 1'b1;
            RX_RANDOM: ready = 1'($urandom_range(0, 1));
            RX_SPARSE: ready = ($urandom_range(0, 3) == 0);
            default: begin
               ready   = pattern[0];
               pattern = {pattern[0], pattern[15:1]};
            end
         endcase
         rsp_tready <= ready && !hold_rsp;
      end
   end

   // One long receiver stall while the sender keeps offering items.
   initial begin
      wait (long_hold_go);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (LONG_HOLD) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   initial begin
      #40_000_000;
      $display("FAIL decimating_fir_filter");
      $finish;
   end

   // Offers one item and waits for its transaction; bursts end in a random gap, which may be empty.
   task automatic send_item(input logic op, input logic [TAP_W-1:0] tap,
                            input logic [VALUE_W-1:0] value);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {1'b0, value, tap};
      do @(posedge clock); while (!req_tready);
      burst_left--;
      if (burst_left <= 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         burst_left = $urandom_range(1, 40);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            req_tuser  <= 1'($urandom);
            req_tdata  <= 24'($urandom);
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Both registers are written back to back while the block is idle.
   task automatic write_regs(input logic [DEC_W-1:0] dec, input logic [GAIN_W-1:0] gain);
      csr_valid <= 1'b1;
      csr_index <= CSR_DECIMATION;
      csr_data  <= CSR_D_W'(dec);
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_GAIN;
      csr_data  <= gain;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Stops offering items until every expected output has come and the pipeline is quiet.
   // The first edge lets the monitor note the last accepted item before the count is read.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic send_random_item();
      logic             op;
      logic [VALUE_W-1:0] value;
      op = ($urandom_range(0, 99) < 85) ? OP_PUSH : OP_LOAD;
      case ($urandom_range(0, 9))
         0:       value = 16'h7FFF;
         1:       value = 16'h8000;
         default: value = 16'($urandom);
      endcase
      send_item(op, 7'($urandom_range(0, 127)), value);
   endtask

   initial begin
      logic [DEC_W-1:0]  dec;
      logic [GAIN_W-1:0] gain;
      int                n_items;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tuser  = OP_LOAD;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_index  = CSR_DECIMATION;
      csr_data   = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: every tap at the negative extreme, loads past the last tap
      // are dropped, then a full window of negative extremes and a positive run.
      for (int k = 0; k < TAPS; k++) begin
         send_item(OP_LOAD, 7'(k), 16'h8000);
      end
      send_item(OP_LOAD, 7'(TAPS), 16'h7FFF);
      send_item(OP_LOAD, 7'd127, 16'h7FFF);
      repeat (TAPS) send_item(OP_PUSH, 7'($urandom), 16'h8000);
      repeat (10) send_item(OP_PUSH, 7'd0, 16'h7FFF);
      drain();

      // Largest gain with an output on every push drives the result into saturation.
      write_regs(8'd1, 17'h1FFFF);
      send_item(OP_PUSH, 7'd0, 16'h7FFF);
      send_item(OP_PUSH, 7'd0, 16'h8000);
      send_item(OP_PUSH, 7'd0, 16'h0000);
      send_item(OP_PUSH, 7'd0, 16'h0001);
      send_item(OP_PUSH, 7'd0, 16'hFFFF);
      send_item(OP_LOAD, 7'd0, 16'h7FFF);
      send_item(OP_LOAD, 7'(TAPS - 1), 16'h0001);
      send_item(OP_PUSH, 7'd127, 16'h1234);
      drain();

      // Decimation zero behaves as one; zero gain gives zero.
      write_regs(8'd0, 17'd0);
      repeat (3) send_item(OP_PUSH, 7'($urandom), 16'($urandom));
      drain();

      // Largest decimation builds up a long phase count without an output.
      write_regs(8'd255, 17'h10000);
      repeat (100) send_item(OP_PUSH, 7'($urandom), 16'($urandom));
      drain();

      // Random phases; the first one lowers decimation below the running phase count.
      for (int p = 0; p < RAND_PHASES; p++) begin
         case ($urandom_range(0, 5))
            0, 1, 2: dec = DEC_W'($urandom_range(1, 12));
            3:       dec = DEC_W'($urandom_range(0, 1));
            4:       dec = DEC_W'($urandom_range(13, 40));
            default: dec = DEC_W'($urandom_range(41, 255));
         endcase
         case ($urandom_range(0, 4))
            0:       gain = GAIN_W'($urandom_range(0, 131071));
            1:       gain = '0;
            2:       gain = '1;
            3:       gain = GAIN_RESET;
            default: gain = GAIN_W'($urandom_range(1, 4096));
         endcase
         if (p == 0) begin
            dec = 8'd3;
         end else if (p == 2) begin
            dec = 8'd2;
         end
         write_regs(dec, gain);
         n_items = $urandom_range(80, 150);
         for (int i = 0; i < n_items; i++) begin
            if (p == 2 && i == 10) begin
               long_hold_go <= 1'b1;
            end
            send_random_item();
         end
         drain();
      end

      sb.close_out();
      if (sb.mismatches == 0) begin
         $display("PASS decimating_fir_filter");
      end else begin
         $display("FAIL decimating_fir_filter");
      end
      $finish;
   end

endmodule
